@@ src/pbre_pkg.sv @@
// shared types, codes and the cordic angle table of the reach envelope
`timescale 1ns / 1ps
`default_nettype none
package pbre_pkg;

	// request codes
	localparam logic [1:0] REQ_CLEAR  = 2'd0;
	localparam logic [1:0] REQ_INSERT = 2'd1;
	localparam logic [1:0] REQ_QUERY  = 2'd2;
	// spare code, answered with in_volume low and otherwise ignored
	localparam logic [1:0] REQ_UNUSED = 2'd3;

	// configuration register indexes
	localparam logic [1:0] REG_LAYER_COUNT  = 2'd0;
	localparam logic [1:0] REG_SECTOR_COUNT = 2'd1;
	localparam logic [1:0] REG_MAX_HEIGHT   = 2'd2;

	// smallest bin reach seen by a query, 1.0 in q12
	localparam logic [23:0] ONE_Q12 = 24'd4096;

	// classified item handed from the front to the back
	typedef struct packed {
		logic [1:0]  req;
		logic [7:0]  layer;
		logic [7:0]  sector;
		logic [23:0] dst;
		logic [23:0] wall_val;
		logic        near;
		logic        py_ok;
	} pbre_item_t;

	// atan(2^-i) in units of 2^-32 turn
	function automatic logic [29:0] atan_turn(input logic [4:0] idx);
		logic [29:0] v;
		unique case (idx)
			5'd0:  v = 30'd536870912;
			5'd1:  v = 30'd316933406;
			5'd2:  v = 30'd167458907;
			5'd3:  v = 30'd85004756;
			5'd4:  v = 30'd42667331;
			5'd5:  v = 30'd21354465;
			5'd6:  v = 30'd10679838;
			5'd7:  v = 30'd5340245;
			5'd8:  v = 30'd2670163;
			5'd9:  v = 30'd1335087;
			5'd10: v = 30'd667544;
			5'd11: v = 30'd333772;
			5'd12: v = 30'd166886;
			5'd13: v = 30'd83443;
			5'd14: v = 30'd41722;
			5'd15: v = 30'd20861;
			5'd16: v = 30'd10430;
			5'd17: v = 30'd5215;
			5'd18: v = 30'd2608;
			5'd19: v = 30'd1304;
			5'd20: v = 30'd652;
			5'd21: v = 30'd326;
			5'd22: v = 30'd163;
			5'd23: v = 30'd81;
			default: v = 30'd0;
		endcase
		return v;
	endfunction

endpackage
`default_nettype wire

@@ src/polar_bin_reach_envelope.sv @@
// top level of the polar bin reach envelope: config registers, front, queue, back
// front: classifies one transfer at a time and takes the next only after its item enters the queue
// back: a query reads and compares its bin (no read before the first clear), a layer insert every sector
// clear: one table entry per cycle on the single memory port
// reset: a clearing pass over all MAX_LAYERS*MAX_SECTORS entries runs first; in_ready stays low
`timescale 1ns / 1ps
`default_nettype none
module polar_bin_reach_envelope #(
	parameter int MAX_LAYERS   = 128,
	parameter int MAX_SECTORS  = 128,
	parameter int CORDIC_STEPS = 16
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               cfg_en,
	input  wire logic [1:0]         cfg_addr,
	input  wire logic [22:0]        cfg_data,
	input  wire logic               in_valid,
	output logic                    in_ready,
	input  wire logic [1:0]         req_type,
	input  wire logic signed [23:0] pos_x,
	input  wire logic signed [23:0] pos_y,
	input  wire logic signed [23:0] pos_z,
	input  wire logic [22:0]        thickness,
	output logic                    out_valid,
	input  wire logic               out_ready,
	output logic                    in_volume,
	output logic [6:0]              layer_index,
	output logic [6:0]              sector_index,
	output logic [23:0]             distance
);
	import pbre_pkg::*;

	logic [7:0]  layer_count_q;
	logic [7:0]  sector_count_q;
	logic [22:0] max_height_q;
	logic [7:0]  nl;
	logic [7:0]  ns;
	logic        hold;
	logic        push_valid;
	logic        push_ready;
	pbre_item_t  push_item;
	logic        pop_valid;
	logic        pop_ready;
	pbre_item_t  pop_item;

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			layer_count_q  <= 8'd1;
			sector_count_q <= 8'd1;
			max_height_q   <= 23'd4096;
		end else if (cfg_en) begin
			unique case (cfg_addr)
				REG_LAYER_COUNT:  layer_count_q  <= cfg_data[7:0];
				REG_SECTOR_COUNT: sector_count_q <= cfg_data[7:0];
				REG_MAX_HEIGHT:   max_height_q   <= cfg_data;
				default: ;
			endcase
		end
	end

	// effective counts, zero acts as one and the table size caps them
	always_comb begin
		if (layer_count_q == '0)
			nl = 8'd1;
		else if (11'(layer_count_q) > 11'(MAX_LAYERS))
			nl = 8'(MAX_LAYERS);
		else
			nl = layer_count_q;
		if (sector_count_q == '0)
			ns = 8'd1;
		else if (11'(sector_count_q) > 11'(MAX_SECTORS))
			ns = 8'(MAX_SECTORS);
		else
			ns = sector_count_q;
	end

	pbre_front #(
		.CORDIC_STEPS(CORDIC_STEPS)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.req_type   (req_type),
		.pos_x      (pos_x),
		.pos_y      (pos_y),
		.pos_z      (pos_z),
		.thickness  (thickness),
		.nl         (nl),
		.ns         (ns),
		.max_height (max_height_q),
		.hold       (hold),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_item  (push_item)
	);

	pbre_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_item  (push_item),
		.pop_valid  (pop_valid),
		.pop_ready  (pop_ready),
		.pop_item   (pop_item)
	);

	pbre_back #(
		.MAX_LAYERS  (MAX_LAYERS),
		.MAX_SECTORS (MAX_SECTORS)
	) u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.pop_valid    (pop_valid),
		.pop_ready    (pop_ready),
		.pop_item     (pop_item),
		.ns           (ns),
		.init_busy    (hold),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.in_volume    (in_volume),
		.layer_index  (layer_index),
		.sector_index (sector_index),
		.distance     (distance)
	);

endmodule
`default_nettype wire

@@ src/pbre_front.sv @@
// front end: takes a point, finds layer, sector and distance step by step
`timescale 1ns / 1ps
`default_nettype none
module pbre_front #(
	parameter int CORDIC_STEPS = 16
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               in_valid,
	output logic                    in_ready,
	input  wire logic [1:0]         req_type,
	input  wire logic signed [23:0] pos_x,
	input  wire logic signed [23:0] pos_y,
	input  wire logic signed [23:0] pos_z,
	input  wire logic [22:0]        thickness,
	input  wire logic [7:0]         nl,
	input  wire logic [7:0]         ns,
	input  wire logic [22:0]        max_height,
	input  wire logic               hold,
	output logic                    push_valid,
	input  wire logic               push_ready,
	output pbre_pkg::pbre_item_t    push_item
);
	import pbre_pkg::*;

	localparam logic [5:0] CNT_SQ0      = 6'd0;
	localparam logic [5:0] CNT_SQ1      = 6'd1;
	localparam logic [5:0] CNT_ROOT0    = 6'd2;
	localparam logic [5:0] CNT_ROOT_END = 6'd25;
	localparam logic [5:0] CNT_DIV_END  = 6'd30;
	localparam logic [5:0] CNT_MUL      = 6'd31;
	localparam logic [5:0] CNT_DONE     = 6'd32;
	localparam logic [5:0] CNT_CORDIC   = 6'(CORDIC_STEPS);

	logic               busy_q;
	logic [5:0]         cnt_q;
	logic [1:0]         req_q;
	logic [22:0]        thick_q;
	logic               py_ok_q;
	logic               lzero_q;
	logic               onaxis_q;
	logic signed [23:0] px_q;
	logic signed [23:0] pz_q;
	logic signed [26:0] ca_q;
	logic signed [26:0] cb_q;
	logic signed [33:0] ang_q;
	logic [47:0]        sq_q;
	logic [25:0]        rem_q;
	logic [23:0]        root_q;
	logic [30:0]        num_q;
	logic [22:0]        drem_q;
	logic [30:0]        quo_q;
	logic [39:0]        prod_q;

	logic               accept;
	logic signed [26:0] a0;
	logic signed [26:0] b0;
	logic signed [33:0] ang0;
	logic [4:0]         step_i;
	logic signed [26:0] da;
	logic signed [26:0] db;
	logic signed [33:0] atan_s;
	logic signed [23:0] mul_in;
	logic signed [47:0] sqr;
	logic [27:0]        rem_ext;
	logic [27:0]        trial;
	logic [23:0]        drem_ext;
	logic signed [34:0] u_ext;
	logic [31:0]        u32;
	logic [7:0]         lay;
	logic [7:0]         sec8;
	logic [7:0]         sec;
	logic [24:0]        wall_sum;

	assign in_ready = !busy_q && !hold;
	assign accept   = in_valid && in_ready;

	// quarter-turn pre-rotation into the right half plane
	always_comb begin
		a0   = 27'(pos_z);
		b0   = 27'(pos_x);
		ang0 = '0;
		if (pos_z < 24'sd0) begin
			if (pos_x >= 24'sd0) begin
				a0   = 27'(pos_x);
				b0   = -27'(pos_z);
				ang0 = 34'sd1073741824;
			end else begin
				a0   = -27'(pos_x);
				b0   = 27'(pos_z);
				ang0 = -34'sd1073741824;
			end
		end
	end

	// one cordic micro-rotation per cycle
	assign step_i = cnt_q[4:0];
	assign da     = cb_q >>> step_i;
	assign db     = ca_q >>> step_i;
	assign atan_s = $signed({4'b0000, atan_turn(step_i)});

	// shared squarer
	assign mul_in = (cnt_q == CNT_SQ0) ? px_q : pz_q;
	assign sqr    = mul_in * mul_in;

	// digit-by-digit square root step
	assign rem_ext = {rem_q, sq_q[47:46]};
	assign trial   = {2'b00, root_q, 2'b01};

	// restoring divider step
	assign drem_ext = {drem_q, num_q[30]};

	// offset angle, clamped to an unsigned fraction of a turn
	always_comb begin
		u_ext = 35'(ang_q) + 35'sd2147483648;
		if (u_ext < 35'sd0)
			u32 = '0;
		else if (u_ext > 35'sd4294967295)
			u32 = '1;
		else
			u32 = u_ext[31:0];
	end

	// final bins and insert values
	always_comb begin
		if (lzero_q)
			lay = '0;
		else if (quo_q >= 31'(nl))
			lay = nl - 8'd1;
		else
			lay = quo_q[7:0];
		sec8 = prod_q[39:32];
		if (onaxis_q)
			sec = '0;
		else if (sec8 >= ns)
			sec = ns - 8'd1;
		else
			sec = sec8;
		wall_sum = 25'(root_q) + 25'(thick_q);
	end

	always_comb begin
		push_item.req      = req_q;
		push_item.layer    = lay;
		push_item.sector   = sec;
		push_item.dst      = root_q;
		push_item.wall_val = wall_sum[24] ? 24'hFFFFFF : wall_sum[23:0];
		push_item.near     = root_q <= {1'b0, thick_q};
		push_item.py_ok    = py_ok_q;
	end

	assign push_valid = busy_q && (cnt_q == CNT_DONE);

	// sequencing
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (accept) begin
			busy_q <= 1'b1;
			cnt_q  <= '0;
		end else if (busy_q) begin
			if (cnt_q != CNT_DONE)
				cnt_q <= cnt_q + 6'd1;
			else if (push_ready)
				busy_q <= 1'b0;
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		if (accept) begin
			req_q    <= req_type;
			thick_q  <= thickness;
			py_ok_q  <= pos_y <= $signed({1'b0, max_height});
			lzero_q  <= (pos_y <= 24'sd0) || (max_height == '0);
			onaxis_q <= (pos_x == '0) && (pos_z == '0);
			px_q     <= pos_x;
			pz_q     <= pos_z;
			ca_q     <= a0;
			cb_q     <= b0;
			ang_q    <= ang0;
			rem_q    <= '0;
			root_q   <= '0;
			num_q    <= 31'(pos_y[22:0]) * 31'(nl);
			drem_q   <= '0;
			quo_q    <= '0;
		end else if (busy_q) begin
			if (cnt_q < CNT_CORDIC) begin
				if (cb_q > 27'sd0) begin
					ca_q  <= ca_q + da;
					cb_q  <= cb_q - db;
					ang_q <= ang_q + atan_s;
				end else begin
					ca_q  <= ca_q - da;
					cb_q  <= cb_q + db;
					ang_q <= ang_q - atan_s;
				end
			end
			if (cnt_q == CNT_SQ0)
				sq_q <= sqr;
			else if (cnt_q == CNT_SQ1)
				sq_q <= sq_q + sqr;
			else if (cnt_q >= CNT_ROOT0 && cnt_q <= CNT_ROOT_END) begin
				sq_q <= {sq_q[45:0], 2'b00};
				if (rem_ext >= trial) begin
					rem_q  <= 26'(rem_ext - trial);
					root_q <= {root_q[22:0], 1'b1};
				end else begin
					rem_q  <= rem_ext[25:0];
					root_q <= {root_q[22:0], 1'b0};
				end
			end
			if (cnt_q <= CNT_DIV_END) begin
				num_q <= {num_q[29:0], 1'b0};
				if (drem_ext >= {1'b0, max_height}) begin
					drem_q <= 23'(drem_ext - {1'b0, max_height});
					quo_q  <= {quo_q[29:0], 1'b1};
				end else begin
					drem_q <= drem_ext[22:0];
					quo_q  <= {quo_q[29:0], 1'b0};
				end
			end
			if (cnt_q == CNT_MUL)
				prod_q <= 40'(u32) * 40'(ns);
		end
	end

endmodule
`default_nettype wire

@@ src/pbre_queue.sv @@
// two-entry queue between the front and the back
`timescale 1ns / 1ps
`default_nettype none
module pbre_queue (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 push_valid,
	output logic                      push_ready,
	input  wire pbre_pkg::pbre_item_t push_item,
	output logic                      pop_valid,
	input  wire logic                 pop_ready,
	output pbre_pkg::pbre_item_t      pop_item
);
	import pbre_pkg::*;

	pbre_item_t ent_q [2];
	logic       wr_q;
	logic       rd_q;
	logic [1:0] cnt_q;
	logic       do_push;
	logic       do_pop;

	assign push_ready = cnt_q != 2'd2;
	assign pop_valid  = cnt_q != 2'd0;
	assign pop_item   = ent_q[rd_q];
	assign do_push    = push_valid && push_ready;
	assign do_pop     = pop_valid && pop_ready;

	// pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= 1'b0;
			rd_q  <= 1'b0;
			cnt_q <= '0;
		end else begin
			if (do_push)
				wr_q <= !wr_q;
			if (do_pop)
				rd_q <= !rd_q;
			if (do_push && !do_pop)
				cnt_q <= cnt_q + 2'd1;
			else if (do_pop && !do_push)
				cnt_q <= cnt_q - 2'd1;
		end
	end

	// entry storage
	always_ff @(posedge clk) begin
		if (do_push)
			ent_q[wr_q] <= push_item;
	end

endmodule
`default_nettype wire

@@ src/pbre_back.sv @@
// back end: reach table memory, clear sweep, bin updates and query answers
`timescale 1ns / 1ps
`default_nettype none
module pbre_back #(
	parameter int MAX_LAYERS  = 128,
	parameter int MAX_SECTORS = 128
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 pop_valid,
	output logic                      pop_ready,
	input  wire pbre_pkg::pbre_item_t pop_item,
	input  wire logic [7:0]           ns,
	output logic                      init_busy,
	output logic                      out_valid,
	input  wire logic                 out_ready,
	output logic                      in_volume,
	output logic [6:0]                layer_index,
	output logic [6:0]                sector_index,
	output logic [23:0]               distance
);
	import pbre_pkg::*;

	localparam int DEPTH = MAX_LAYERS * MAX_SECTORS;
	localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

	localparam logic [2:0] ST_INIT = 3'd0;
	localparam logic [2:0] ST_IDLE = 3'd1;
	localparam logic [2:0] ST_CLR  = 3'd2;
	localparam logic [2:0] ST_RD   = 3'd3;
	localparam logic [2:0] ST_CMP  = 3'd4;
	localparam logic [2:0] ST_RES  = 3'd5;

	logic [23:0]   mem [DEPTH];
	logic [23:0]   rdata_q;
	logic [2:0]    state_q;
	logic [AW-1:0] clr_q;
	logic          valid_q;
	pbre_item_t    cur_q;
	logic [7:0]    sidx_q;
	logic          ans_q;
	logic          out_valid_q;
	logic          out_vol_q;
	logic [7:0]    out_layer_q;
	logic [7:0]    out_sector_q;
	logic [23:0]   out_dist_q;

	logic          wall;
	logic [AW-1:0] base;
	logic [7:0]    col;
	logic [AW-1:0] mem_addr;
	logic          mem_we;
	logic [23:0]   mem_wdata;
	logic          clr_last;
	logic [23:0]   bin_v;
	logic          out_free;

	assign wall      = (cur_q.req == REQ_INSERT) && cur_q.near;
	assign base      = AW'(32'(cur_q.layer) * 32'(MAX_SECTORS));
	assign col       = wall ? sidx_q : cur_q.sector;
	assign clr_last  = clr_q == AW'(DEPTH - 1);
	assign bin_v     = (rdata_q < ONE_Q12) ? ONE_Q12 : rdata_q;
	assign out_free  = !out_valid_q || out_ready;
	assign pop_ready = state_q == ST_IDLE;
	assign init_busy = state_q == ST_INIT;

	// memory address and write selection
	always_comb begin
		mem_addr  = base + AW'(col);
		mem_we    = 1'b0;
		mem_wdata = '0;
		if (state_q == ST_INIT || state_q == ST_CLR) begin
			mem_addr = clr_q;
			mem_we   = 1'b1;
		end else if (state_q == ST_CMP && cur_q.req == REQ_INSERT) begin
			if (wall) begin
				mem_we    = rdata_q < cur_q.wall_val;
				mem_wdata = cur_q.wall_val;
			end else begin
				mem_we    = rdata_q < cur_q.dst;
				mem_wdata = cur_q.dst;
			end
		end
	end

	// reach table
	always_ff @(posedge clk) begin
		if (mem_we)
			mem[mem_addr] <= mem_wdata;
		rdata_q <= mem[mem_addr];
	end

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_INIT;
			clr_q       <= '0;
			valid_q     <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			// result register: loaded by a finished item, emptied by a transfer
			if (state_q == ST_RES && out_free)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;
			unique case (state_q)
				ST_INIT: begin
					if (clr_last) begin
						clr_q   <= '0;
						state_q <= ST_IDLE;
					end else begin
						clr_q <= clr_q + AW'(1);
					end
				end
				ST_IDLE: begin
					if (pop_valid) begin
						unique case (pop_item.req)
							REQ_CLEAR:  state_q <= ST_CLR;
							REQ_INSERT: state_q <= ST_RD;
							REQ_QUERY:  state_q <= valid_q ? ST_RD : ST_RES;
							default:    state_q <= ST_RES;
						endcase
					end
				end
				ST_CLR: begin
					if (clr_last) begin
						clr_q   <= '0;
						valid_q <= 1'b1;
						state_q <= ST_RES;
					end else begin
						clr_q <= clr_q + AW'(1);
					end
				end
				ST_RD: state_q <= ST_CMP;
				ST_CMP: begin
					if (wall && sidx_q != ns - 8'd1)
						state_q <= ST_RD;
					else
						state_q <= ST_RES;
				end
				ST_RES: begin
					if (out_free)
						state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// item and result payload
	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && pop_valid) begin
			cur_q  <= pop_item;
			sidx_q <= '0;
			ans_q  <= (pop_item.req == REQ_QUERY) && !valid_q;
		end
		if (state_q == ST_CMP) begin
			sidx_q <= sidx_q + 8'd1;
			if (cur_q.req == REQ_QUERY)
				ans_q <= (bin_v >= cur_q.dst) && cur_q.py_ok;
		end
		if (state_q == ST_RES && out_free) begin
			out_vol_q    <= ans_q;
			out_layer_q  <= cur_q.layer;
			out_sector_q <= cur_q.sector;
			out_dist_q   <= cur_q.dst;
		end
	end

	assign out_valid    = out_valid_q;
	assign in_volume    = out_vol_q;
	assign layer_index  = out_layer_q[6:0];
	assign sector_index = out_sector_q[6:0];
	assign distance     = out_dist_q;

endmodule
`default_nettype wire

@@ src/pbre_checker.sv @@
// port-level checks of the reach envelope and their bind to the top level
`timescale 1ns / 1ps
`default_nettype none
module pbre_checker (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        in_valid,
	input wire logic        in_ready,
	input wire logic        out_valid,
	input wire logic        out_ready,
	input wire logic        in_volume,
	input wire logic [23:0] distance
);

	// a stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(distance) && $stable(in_volume))
		else $error("stalled result changed");

	// the front works on one item at a time
	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("second transfer taken while busy");

	// distance of a 24 bit signed point never passes sqrt(2^47)
	a_dist_bound: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> distance <= 24'd11863283)
		else $error("distance out of range");

	// start of the table sweep after reset: nothing taken, nothing shown
	a_reset_sweep: assert property (@(posedge clk)
		$rose(arst_n) |-> !out_valid && !in_ready)
		else $error("activity during reset sweep");

endmodule

bind polar_bin_reach_envelope pbre_checker u_chk (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_valid),
	.in_ready  (in_ready),
	.out_valid (out_valid),
	.out_ready (out_ready),
	.in_volume (in_volume),
	.distance  (distance)
);
`default_nettype wire

@@ tb/tb_polar_bin_reach_envelope.sv @@
// testbench for the polar bin reach envelope: directed and random traffic checked against a predictor
`timescale 1ns / 1ps
`default_nettype none
module tb_polar_bin_reach_envelope;
	import pbre_pkg::*;

	localparam int  TBL_LAYERS  = 128;
	localparam int  TBL_SECTORS = 128;
	localparam int  ANGLE_STEPS = 16;
	localparam int  SETTLE      = 400;
	localparam longint CYCLE_LIMIT = 6000000;
	localparam int  HOLD_AFTER  = 600;
	localparam int  HOLD_CYCLES = 3000;

	logic               clk;
	logic               arst_n;
	logic               cfg_en;
	logic [1:0]         cfg_addr;
	logic [22:0]        cfg_data;
	logic               in_valid;
	logic               in_ready;
	logic [1:0]         req_type;
	logic signed [23:0] pos_x;
	logic signed [23:0] pos_y;
	logic signed [23:0] pos_z;
	logic [22:0]        thickness;
	logic               out_valid;
	logic               out_ready;
	logic               in_volume;
	logic [6:0]         layer_index;
	logic [6:0]         sector_index;
	logic [23:0]        distance;

	// one expected answer of the block
	typedef struct {
		bit        in_vol;
		bit [6:0]  layer;
		bit [6:0]  sector;
		bit [23:0] dst;
	} reach_answer_t;

	// envelope predictor with the queue of pending answers
	class reach_scoreboard;
		bit [23:0]     reach [TBL_LAYERS*TBL_SECTORS];
		bit            valid;
		int unsigned   layers_reg;
		int unsigned   sectors_reg;
		int unsigned   height_reg;
		reach_answer_t pending[$];
		int            errors;
		longint        atan_tab [24];

		function new();
			atan_tab = '{536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
				10679838, 5340245, 2670163, 1335087, 667544, 333772,
				166886, 83443, 41722, 20861, 10430, 5215, 2608, 1304, 652, 326, 163, 81};
			foreach (reach[i]) reach[i] = '0;
			valid = 0;
			layers_reg = 1;
			sectors_reg = 1;
			height_reg = 4096;
			errors = 0;
		endfunction

		function void set_reg(logic [1:0] idx, logic [22:0] val);
			case (idx)
				REG_LAYER_COUNT:  layers_reg = 32'(val[7:0]);
				REG_SECTOR_COUNT: sectors_reg = 32'(val[7:0]);
				REG_MAX_HEIGHT:   height_reg = 32'(val);
				default: ;
			endcase
		endfunction

		function int unsigned clamp_count(int unsigned v, int unsigned cap);
			if (v == 0)
				return 1;
			return (v > cap) ? cap : v;
		endfunction

		// vectoring rotation, angle of (a, b) in 2^-32 turn
		function longint turn_angle(longint a, longint b);
			longint ang;
			longint t;
			longint da;
			longint db;
			ang = 0;
			if (a < 0) begin
				t = a;
				if (b >= 0) begin
					a = b;
					b = -t;
					ang = 1073741824;
				end else begin
					a = -b;
					b = t;
					ang = -1073741824;
				end
			end
			for (int i = 0; i < ANGLE_STEPS; i++) begin
				da = b >>> i;
				db = a >>> i;
				if (b > 0) begin
					a += da;
					b -= db;
					ang += atan_tab[i];
				end else begin
					a -= da;
					b += db;
					ang -= atan_tab[i];
				end
			end
			return ang;
		endfunction

		function longint unsigned root_floor(longint unsigned v);
			longint unsigned res;
			longint unsigned bitv;
			res = 0;
			bitv = 64'd1 << 62;
			while (bitv > v)
				bitv >>= 2;
			while (bitv != 0) begin
				if (v >= res + bitv) begin
					v -= res + bitv;
					res = (res >> 1) + bitv;
				end else begin
					res >>= 1;
				end
				bitv >>= 2;
			end
			return res;
		endfunction

		// predict the answer of one accepted request and update the table
		function void note_request(logic [1:0] req, logic signed [23:0] px,
				logic signed [23:0] py, logic signed [23:0] pz, logic [22:0] th);
			int unsigned   nl;
			int unsigned   ns;
			int unsigned   lay;
			int unsigned   sec;
			longint        x;
			longint        y;
			longint        z;
			longint        u;
			longint unsigned q;
			bit [23:0]     d;
			bit [23:0]     bin;
			bit [24:0]     wall;
			reach_answer_t r;
			nl = clamp_count(layers_reg, TBL_LAYERS);
			ns = clamp_count(sectors_reg, TBL_SECTORS);
			x = px;
			y = py;
			z = pz;
			lay = 0;
			sec = 0;
			if (y > 0 && height_reg != 0) begin
				q = (longint'(y) * nl) / height_reg;
				lay = (q >= nl) ? nl - 1 : int'(q);
			end
			if (x != 0 || z != 0) begin
				u = turn_angle(z, x) + 64'sd2147483648;
				if (u < 0)
					u = 0;
				if (u > 64'sd4294967295)
					u = 64'sd4294967295;
				q = (longint'(u) * ns) >> 32;
				sec = (q >= ns) ? ns - 1 : int'(q);
			end
			d = 24'(root_floor(longint'(x * x + z * z)));
			r.in_vol = 0;
			case (req)
				REQ_CLEAR: begin
					foreach (reach[i]) reach[i] = '0;
					valid = 1;
				end
				REQ_INSERT: begin
					if (d <= th) begin
						wall = 25'(d) + 25'(th);
						if (wall > 25'hFFFFFF)
							wall = 25'hFFFFFF;
						for (int s = 0; s < ns; s++)
							if (reach[lay*TBL_SECTORS + s] < wall[23:0])
								reach[lay*TBL_SECTORS + s] = wall[23:0];
					end else if (reach[lay*TBL_SECTORS + sec] < d) begin
						reach[lay*TBL_SECTORS + sec] = d;
					end
				end
				REQ_QUERY: begin
					if (!valid) begin
						r.in_vol = 1;
					end else begin
						bin = reach[lay*TBL_SECTORS + sec];
						if (bin < ONE_Q12)
							bin = ONE_Q12;
						r.in_vol = (bin >= d) && (y <= longint'(height_reg));
					end
				end
				default: ;
			endcase
			r.layer = lay[6:0];
			r.sector = sec[6:0];
			r.dst = d;
			pending = {pending, r};
		endfunction

		task report(string what, longint want, longint got);
			$display("mismatch %s: expected %0d got %0d", what, want, got);
			errors++;
		endtask

		task check_result(bit iv, bit [6:0] li, bit [6:0] si, bit [23:0] d);
			reach_answer_t r;
			if (pending.size() == 0) begin
				report("unexpected transfer", 0, 1);
				return;
			end
			r = pending.pop_front();
			if (iv != r.in_vol)
				report("in_volume", r.in_vol, iv);
			if (li != r.layer)
				report("layer_index", r.layer, li);
			if (si != r.sector)
				report("sector_index", r.sector, si);
			if (d != r.dst)
				report("distance", r.dst, d);
		endtask
	endclass

	reach_scoreboard sb;
	bit     steady;
	longint cycles;
	int     answers_seen;
	logic signed [23:0] recent_x[$];
	logic signed [23:0] recent_z[$];
	logic signed [23:0] recent_y[$];

	polar_bin_reach_envelope u_dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_en      (cfg_en),
		.cfg_addr    (cfg_addr),
		.cfg_data    (cfg_data),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.req_type    (req_type),
		.pos_x       (pos_x),
		.pos_y       (pos_y),
		.pos_z       (pos_z),
		.thickness   (thickness),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.in_volume   (in_volume),
		.layer_index (layer_index),
		.sector_index(sector_index),
		.distance    (distance)
	);

	// clock
	initial clk = 0;
	always #5 clk = ~clk;

	// run limit
	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("FAIL polar_bin_reach_envelope");
			$finish;
		end
	end

	// result side: check transfers, random stalls, one long hold
	initial begin : result_side
		int hold_left;
		bit held;
		hold_left = 0;
		held = 0;
		forever begin
			@(posedge clk);
			if (out_valid && out_ready) begin
				sb.check_result(in_volume, layer_index, sector_index, distance);
				answers_seen++;
			end
			if (!held && answers_seen >= HOLD_AFTER) begin
				held = 1;
				hold_left = HOLD_CYCLES;
				out_ready <= 1'b0;
			end else if (hold_left > 0) begin
				hold_left--;
				out_ready <= 1'b0;
			end else begin
				out_ready <= steady || ($urandom_range(0, 99) >= 20);
			end
		end
	end

	task write_reg(logic [1:0] idx, logic [22:0] val);
		cfg_en <= 1'b1;
		cfg_addr <= idx;
		cfg_data <= val;
		sb.set_reg(idx, val);
		@(posedge clk);
	endtask

	// one request transfer, with a random gap before it unless steady is set
	task send_request(logic [1:0] req, logic signed [23:0] x, logic signed [23:0] y,
			logic signed [23:0] z, logic [22:0] th);
		if (!steady)
			while ($urandom_range(0, 99) < 20) begin
				in_valid <= 1'b0;
				@(posedge clk);
			end
		in_valid <= 1'b1;
		req_type <= req;
		pos_x <= x;
		pos_y <= y;
		pos_z <= z;
		thickness <= th;
		do @(posedge clk); while (!in_ready);
		sb.note_request(req, x, y, z, th);
	endtask

	// let every answer arrive and the block go quiet
	task drain();
		in_valid <= 1'b0;
		while (sb.pending.size() != 0)
			@(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	function logic signed [23:0] rand_coord();
		logic signed [23:0] v;
		v = 24'($urandom);
		case ($urandom_range(0, 3))
			0: return v;
			1: return v >>> 4;
			2: return v >>> 8;
			default: return v >>> 11;
		endcase
	endfunction

	function logic signed [23:0] scaled(logic signed [23:0] v);
		longint t;
		t = longint'(v) * longint'($urandom_range(2, 6)) / 4;
		if (t > 8388607)
			t = 8388607;
		if (t < -8388608)
			t = -8388608;
		return 24'(t);
	endfunction

	// random requests, mostly inserts and queries, some queries near recently inserted points
	task random_requests(int count, int unsigned h);
		logic [1:0]         req;
		logic signed [23:0] x;
		logic signed [23:0] y;
		logic signed [23:0] z;
		logic [22:0]        th;
		int unsigned        top;
		int unsigned        r;
		int                 k;
		top = h + h / 8 + 1;
		if (top > 8388607)
			top = 8388607;
		for (int n = 0; n < count; n++) begin
			r = $urandom_range(0, 999);
			if (r < 3)
				req = REQ_CLEAR;
			else if (r < 40)
				req = REQ_UNUSED;
			else if (r < 520)
				req = REQ_INSERT;
			else
				req = REQ_QUERY;
			x = rand_coord();
			z = rand_coord();
			y = ($urandom_range(0, 9) < 7) ? 24'($urandom_range(0, top)) : 24'($urandom);
			if (req == REQ_QUERY && recent_x.size() != 0 && $urandom_range(0, 1)) begin
				k = $urandom_range(0, recent_x.size() - 1);
				x = scaled(recent_x[k]);
				z = scaled(recent_z[k]);
				y = recent_y[k];
			end
			r = $urandom_range(0, 99);
			if (r < 75)
				th = 23'($urandom_range(0, 8192));
			else if (r < 90)
				th = 23'($urandom);
			else
				th = 23'(23'h7FFFFF - $urandom_range(0, 255));
			if (req == REQ_INSERT) begin
				recent_x = {recent_x, x};
				recent_z = {recent_z, z};
				recent_y = {recent_y, y};
				if (recent_x.size() > 32) begin
					void'(recent_x.pop_front());
					void'(recent_z.pop_front());
					void'(recent_y.pop_front());
				end
			end
			send_request(req, x, y, z, th);
		end
	endtask

	// one configuration setting: drain, write, clear, random traffic
	task run_setting(logic [7:0] l, logic [7:0] s, logic [22:0] h, int count, bit no_gaps);
		drain();
		write_reg(REG_LAYER_COUNT, 23'(l));
		write_reg(REG_SECTOR_COUNT, 23'(s));
		write_reg(REG_MAX_HEIGHT, h);
		cfg_en <= 1'b0;
		recent_x.delete();
		recent_z.delete();
		recent_y.delete();
		steady = no_gaps;
		send_request(REQ_CLEAR, rand_coord(), rand_coord(), rand_coord(), 23'($urandom));
		random_requests(count, 32'(h));
	endtask

	initial begin
		sb = new();
		steady = 0;
		cycles = 0;
		answers_seen = 0;
		arst_n = 1'b0;
		cfg_en = 1'b0;
		cfg_addr = '0;
		cfg_data = '0;
		in_valid = 1'b0;
		req_type = REQ_CLEAR;
		pos_x = '0;
		pos_y = '0;
		pos_z = '0;
		thickness = '0;
		out_ready = 1'b0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: reset settings, table not yet valid, then edges of the fields
		send_request(REQ_QUERY, 24'sd5000, 24'sd100, -24'sd7000, 23'd0);
		send_request(REQ_INSERT, 24'sd900000, 24'sd10, 24'sd900000, 23'd5);
		send_request(REQ_QUERY, 24'sd900000, 24'sd8388607, 24'sd900000, 23'd0);
		send_request(REQ_UNUSED, -24'sd8388608, 24'sd8388607, 24'sd8388607, 23'h7FFFFF);
		send_request(REQ_CLEAR, 24'sd0, 24'sd0, 24'sd0, 23'd0);
		send_request(REQ_QUERY, 24'sd0, 24'sd0, 24'sd0, 23'd0);
		send_request(REQ_INSERT, 24'sd0, 24'sd0, 24'sd0, 23'd0);
		send_request(REQ_INSERT, 24'sd100, 24'sd2000, 24'sd0, 23'h7FFFFF);
		send_request(REQ_QUERY, 24'sd8000000, 24'sd4096, 24'sd100, 23'd0);
		send_request(REQ_QUERY, 24'sd100, 24'sd4097, 24'sd100, 23'd0);
		send_request(REQ_INSERT, 24'sd8388607, -24'sd8388608, 24'sd8388607, 23'd0);
		send_request(REQ_QUERY, -24'sd8388608, 24'sd8388607, -24'sd8388608, 23'd0);
		send_request(REQ_QUERY, -24'sd8388608, -24'sd1, -24'sd8388608, 23'd0);
		send_request(REQ_INSERT, -24'sd4096, 24'sd4096, 24'sd0, 23'd1);
		send_request(REQ_QUERY, 24'sd4096, 24'sd1, 24'sd0, 23'd0);
		send_request(REQ_QUERY, 24'sd0, 24'sd1, -24'sd4096, 23'd0);
		send_request(REQ_QUERY, 24'sd0, 24'sd1, 24'sd4096, 23'd0);
		send_request(REQ_INSERT, 24'sd3, 24'sd0, -24'sd8388608, 23'd1);
		send_request(REQ_QUERY, -24'sd3, 24'sd0, -24'sd8388608, 23'd0);

		// settings: widest, small, zero, over the caps, single layer and odd counts
		run_setting(8'd128, 8'd128, 23'h7FFFFF, 275, 1'b0);
		run_setting(8'd8, 8'd16, 23'd40960, 275, 1'b1);
		run_setting(8'd0, 8'd0, 23'd0, 260, 1'b0);
		run_setting(8'd255, 8'd200, 23'd1000, 275, 1'b0);
		run_setting(8'd1, 8'd128, 23'd409600, 275, 1'b0);
		run_setting(8'd37, 8'd5, 23'($urandom_range(1, 8388607)), 275, 1'b0);

		drain();
		if (sb.errors == 0)
			$display("PASS polar_bin_reach_envelope");
		else
			$display("FAIL polar_bin_reach_envelope");
		$finish;
	end

endmodule
`default_nettype wire

@@ filelist.f @@
src/pbre_pkg.sv
src/pbre_front.sv
src/pbre_queue.sv
src/pbre_back.sv
src/polar_bin_reach_envelope.sv
src/pbre_checker.sv
tb/tb_polar_bin_reach_envelope.sv
